FILE: design/bkl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkl_pkg
// Shared types and constants for the bounded key list.
// ----------------------------------------------------------------------------
package bkl_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 3;

  typedef enum logic [OpW-1:0] {
    OP_INSERT    = 3'd0,
    OP_DEL_KEY   = 3'd1,
    OP_DEL_FIRST = 3'd2,
    OP_DEL_LAST  = 3'd3,
    OP_DUMP      = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_ENTRY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_DUMP
  } state_e;

endpackage

FILE: design/bkl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bkl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bkl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: design/bounded_key_list_with_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_key_list_with_delete_top
// Ordered list of up to CAPACITY keys with insert-front, delete by key,
// delete first/last and dump, held in a circular buffer in one RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Insert, delete
// first, delete last and any command on an empty list finish in the cycle
// they are taken; their status beat appears on the next cycle and busy stays
// low. Delete by key scans the RAM from the front at one entry per cycle,
// then closes the gap at one entry per cycle. Dump streams one beat per
// cycle, front first. The single read port of the key RAM sets these rates.
// result_valid_o marks each beat for one cycle; there is no backpressure.
// No clearing pass is needed after reset.
module bounded_key_list_with_delete_top #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op_i,
  input  logic signed [31:0] key_in_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] key_out_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0] CapFull = (CW + 1)'(CAPACITY);
  localparam logic [AW-1:0] HeadMax = AW'(CAPACITY - 1);

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW:0] l);
    logic [AW+1:0] s;
    s = (AW + 2)'(h) + (AW + 2)'(l);
    if (s >= (AW + 2)'(CAPACITY)) begin
      s = s - (AW + 2)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  bkl_pkg::state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [bkl_pkg::KeyW-1:0] key_q, key_d;

  logic                     res_valid_q, res_valid_d;
  bkl_pkg::status_e         status_q, status_d;
  logic [bkl_pkg::KeyW-1:0] key_out_q, key_out_d;
  logic                     last_q, last_d;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [bkl_pkg::KeyW-1:0] wdata, rdata;

  logic [CW:0]   ptr_inc, ptr_inc2, count_ext;
  logic [AW-1:0] head_inc, head_dec;
  logic          accept, is_empty, is_full, match, at_end, at_end2;
  bkl_pkg::op_e  op_w;

  assign busy      = (state_q != bkl_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign op_w      = bkl_pkg::op_e'(op_i);
  assign count_ext = {1'b0, count_q};
  assign ptr_inc   = {1'b0, ptr_q} + (CW + 1)'(1);
  assign ptr_inc2  = {1'b0, ptr_q} + (CW + 1)'(2);
  assign is_empty  = (count_q == '0);
  assign is_full   = (count_ext == CapFull);
  assign match     = (rdata == key_q);
  assign at_end    = (ptr_inc == count_ext);
  assign at_end2   = (ptr_inc2 == count_ext);
  assign head_inc  = (head_q == HeadMax) ? '0 : head_q + AW'(1);
  assign head_dec  = (head_q == '0) ? HeadMax : head_q - AW'(1);

  bkl_ram #(
    .Width(bkl_pkg::KeyW),
    .Depth(CAPACITY)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      bkl_pkg::S_IDLE: begin
        if (accept && !is_empty) begin
          if (op_w == bkl_pkg::OP_DEL_KEY) begin
            state_d = bkl_pkg::S_SEARCH;
          end else if (op_w == bkl_pkg::OP_DUMP) begin
            state_d = bkl_pkg::S_DUMP;
          end
        end
      end
      bkl_pkg::S_SEARCH: begin
        if (match && !at_end) begin
          state_d = bkl_pkg::S_SHIFT;
        end else if (at_end) begin
          state_d = bkl_pkg::S_IDLE;
        end
      end
      bkl_pkg::S_SHIFT: begin
        if (at_end2) begin
          state_d = bkl_pkg::S_IDLE;
        end
      end
      bkl_pkg::S_DUMP: begin
        if (at_end) begin
          state_d = bkl_pkg::S_IDLE;
        end
      end
      default: state_d = bkl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    key_d       = key_q;
    we          = 1'b0;
    waddr       = phys(head_q, {1'b0, ptr_q});
    wdata       = rdata;
    raddr       = phys(head_q, ptr_inc);
    res_valid_d = 1'b0;
    status_d    = bkl_pkg::ST_OK;
    key_out_d   = '0;
    last_d      = 1'b1;
    case (state_q)
      bkl_pkg::S_IDLE: begin
        ptr_d = '0;
        key_d = key_in_i;
        raddr = head_q;
        if (accept) begin
          case (op_w)
            bkl_pkg::OP_INSERT: begin
              res_valid_d = 1'b1;
              if (is_full) begin
                status_d = bkl_pkg::ST_FULL;
              end else begin
                head_d  = head_dec;
                we      = 1'b1;
                waddr   = head_dec;
                wdata   = key_in_i;
                count_d = count_q + CW'(1);
              end
            end
            bkl_pkg::OP_DEL_KEY, bkl_pkg::OP_DUMP: begin
              if (is_empty) begin
                res_valid_d = 1'b1;
                status_d    = bkl_pkg::ST_EMPTY;
              end
            end
            bkl_pkg::OP_DEL_FIRST: begin
              res_valid_d = 1'b1;
              if (is_empty) begin
                status_d = bkl_pkg::ST_EMPTY;
              end else begin
                head_d  = head_inc;
                count_d = count_q - CW'(1);
              end
            end
            bkl_pkg::OP_DEL_LAST: begin
              res_valid_d = 1'b1;
              if (is_empty) begin
                status_d = bkl_pkg::ST_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      bkl_pkg::S_SEARCH: begin
        if (match) begin
          // gap stays at ptr_q; read of ptr_q+1 already issued
          if (at_end) begin
            count_d     = count_q - CW'(1);
            res_valid_d = 1'b1;
          end
        end else if (at_end) begin
          res_valid_d = 1'b1;
          status_d    = bkl_pkg::ST_NOT_FOUND;
        end else begin
          ptr_d = ptr_inc[CW-1:0];
        end
      end
      bkl_pkg::S_SHIFT: begin
        we    = 1'b1;
        raddr = phys(head_q, ptr_inc2);
        ptr_d = ptr_inc[CW-1:0];
        if (at_end2) begin
          count_d     = count_q - CW'(1);
          res_valid_d = 1'b1;
        end
      end
      bkl_pkg::S_DUMP: begin
        res_valid_d = 1'b1;
        status_d    = bkl_pkg::ST_ENTRY;
        key_out_d   = rdata;
        last_d      = at_end;
        ptr_d       = ptr_inc[CW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bkl_pkg::S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    key_q     <= key_d;
    status_q  <= status_d;
    key_out_q <= key_out_d;
    last_q    <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign key_out_o      = key_out_q;
  assign last_o         = last_q;

endmodule
